/* design/tpst_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and byte-building functions of the template page translator.
package tpst_pkg;

    localparam int LINE_BITS_DEF = 20;
    localparam int LINE_OUT_W    = 20;
    localparam int MAX_BEATS     = 9;
    localparam int CNT_W         = 4;
    localparam int PRE_MAX       = 7;
    localparam int IN_TDATA_W    = 8;
    localparam int OUT_TDATA_W   = 32;
    localparam int OUT_TUSER_W   = 3;

    localparam logic [7:0] CH_LT    = 8'h3c;
    localparam logic [7:0] CH_QM    = 8'h3f;
    localparam logic [7:0] CH_EQ    = 8'h3d;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_GT    = 8'h3e;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_BSL   = 8'h5c;
    localparam logic [7:0] CH_DQ    = 8'h22;
    localparam logic [7:0] CH_APOS  = 8'h27;
    localparam logic [7:0] CH_DOT   = 8'h2e;
    localparam logic [7:0] CH_DEL   = 8'h7f;
    localparam logic [7:0] CH_SPACE = 8'h20;

    typedef enum logic [3:0] {
        PS_START    = 4'd0,
        PS_START_LT = 4'd1,
        PS_TEXT     = 4'd2,
        PS_TEXT_LT  = 4'd3,
        PS_TAG_OPEN = 4'd4,
        PS_EXPR     = 4'd5,
        PS_EXPR_Q   = 4'd6,
        PS_CODE     = 4'd7,
        PS_CODE_Q   = 4'd8,
        PS_COMM     = 4'd9,
        PS_COMM_Q   = 4'd10,
        PS_NL1      = 4'd11,
        PS_NL2      = 4'd12
    } t_parse_state;

    // Fixed strings that can open a burst of output bytes.
    typedef enum logic [3:0] {
        PRE_NONE,
        PRE_ECHO_Q,     // echo('
        PRE_ECHO_Q_LT,  // echo('<
        PRE_CLOSE_Q,    // ')<space>
        PRE_ECHO,       // echo(
        PRE_LT,         // <
        PRE_QM,         // ?
        PRE_CLOSE,      // )<space>
        PRE_SPACE       // <space>
    } t_pre_sel;

    typedef enum logic [1:0] {
        TAIL_NONE,
        TAIL_ESC,
        TAIL_RAW
    } t_tail_sel;

    typedef struct packed {
        logic [CNT_W-1:0]          len;
        logic [MAX_BEATS-1:0][7:0] bytes;
    } t_burst;

    typedef struct packed {
        logic [1:0]      len;
        logic [1:0][7:0] bytes;
    } t_tail;

    function automatic t_burst prefix_of(t_pre_sel sel);
        t_burst p;
        p = '0;
        unique case (sel)
            PRE_ECHO_Q: begin
                p.len = CNT_W'(6);
                p.bytes[0] = "e"; p.bytes[1] = "c"; p.bytes[2] = "h";
                p.bytes[3] = "o"; p.bytes[4] = "("; p.bytes[5] = CH_APOS;
            end
            PRE_ECHO_Q_LT: begin
                p.len = CNT_W'(7);
                p.bytes[0] = "e"; p.bytes[1] = "c"; p.bytes[2] = "h";
                p.bytes[3] = "o"; p.bytes[4] = "("; p.bytes[5] = CH_APOS;
                p.bytes[6] = CH_LT;
            end
            PRE_CLOSE_Q: begin
                p.len = CNT_W'(3);
                p.bytes[0] = CH_APOS; p.bytes[1] = ")"; p.bytes[2] = CH_SPACE;
            end
            PRE_ECHO: begin
                p.len = CNT_W'(5);
                p.bytes[0] = "e"; p.bytes[1] = "c"; p.bytes[2] = "h";
                p.bytes[3] = "o"; p.bytes[4] = "(";
            end
            PRE_LT: begin
                p.len = CNT_W'(1);
                p.bytes[0] = CH_LT;
            end
            PRE_QM: begin
                p.len = CNT_W'(1);
                p.bytes[0] = CH_QM;
            end
            PRE_CLOSE: begin
                p.len = CNT_W'(2);
                p.bytes[0] = ")"; p.bytes[1] = CH_SPACE;
            end
            PRE_SPACE: begin
                p.len = CNT_W'(1);
                p.bytes[0] = CH_SPACE;
            end
            default: begin
                p = '0;
            end
        endcase
        return p;
    endfunction

    // Literal text escaping: control bytes 7..13 get a backslash letter,
    // other control bytes and DEL become a dot, quotes and backslash are escaped.
    function automatic t_tail escape_of(logic [7:0] c);
        t_tail t;
        t = '0;
        if (c >= 8'd7 && c <= 8'd13) begin
            t.len = 2'd2;
            t.bytes[0] = CH_BSL;
            unique case (c)
                8'd7:    t.bytes[1] = "a";
                8'd8:    t.bytes[1] = "b";
                8'd9:    t.bytes[1] = "t";
                8'd10:   t.bytes[1] = "n";
                8'd11:   t.bytes[1] = "v";
                8'd12:   t.bytes[1] = "f";
                default: t.bytes[1] = "r";
            endcase
        end else if (c < 8'd32 || c == CH_DEL) begin
            t.len = 2'd1;
            t.bytes[0] = CH_DOT;
        end else if (c == CH_DQ || c == CH_APOS || c == CH_BSL) begin
            t.len = 2'd2;
            t.bytes[0] = CH_BSL;
            t.bytes[1] = c;
        end else begin
            t.len = 2'd1;
            t.bytes[0] = c;
        end
        return t;
    endfunction

endpackage

/* design/template_page_to_script_translator_unit.sv */
`timescale 1ns / 1ps
// Top level of the template page to script translator.
// Template bytes enter on the s_axis side (tuser high marks the end of a template) and
// script bytes leave on the m_axis side, one byte per beat, tlast on the last beat an
// input beat causes. An input beat is parsed in the cycle it is taken and its output
// bytes (up to nine) land in one burst register that drains one beat per cycle while
// m_axis_tready is high. A beat that yields more than one byte holds the input until
// its burst has drained; beats with no output or a single byte go through at one per
// cycle likewise, and the next beat is taken in the same cycle the last burst beat leaves.
module template_page_to_script_translator_unit
    import tpst_pkg::*;
#(
    parameter int LINE_BITS = LINE_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_wr_en,
    input  logic                   i_cfg_wr_data,   // strip_newline_after_tag
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,    // [7:0] in_byte
    input  logic                   s_axis_tuser,    // [0] action (1 = end of template)
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,    // [7:0] out_byte, [27:8] line_number
    output logic [OUT_TUSER_W-1:0] m_axis_tuser,    // [0] byte_valid, [1] syntax_error,
                                                    // [2] finished
    output logic                   m_axis_tlast
);

    localparam int LW = (LINE_BITS > LINE_OUT_W) ? LINE_BITS : LINE_OUT_W;

    logic                      r_strip;
    t_parse_state              r_state, n_state;
    logic [LINE_BITS-1:0]      r_line,  n_line;

    logic [MAX_BEATS-1:0][7:0] r_buf;
    logic [CNT_W-1:0]          r_cnt;
    logic                      r_bv;
    logic                      r_err;
    logic                      r_end;
    logic [LINE_OUT_W-1:0]     r_line_out;

    logic                      in_fire, out_fire;
    logic                      is_end;
    logic [7:0]                c;
    logic                      start_like;
    t_pre_sel                  pre_sel;
    t_tail_sel                 tail_sel;
    logic                      end_err;
    t_burst                    pre;
    t_tail                     esc, tail;
    t_burst                    burst;
    logic [LW-1:0]             line_wide;
    logic [LINE_OUT_W-1:0]     line_out;

    assign is_end   = s_axis_tuser;
    assign c        = s_axis_tdata;
    assign out_fire = m_axis_tvalid && m_axis_tready;
    assign s_axis_tready = (r_cnt == '0) || (r_cnt == CNT_W'(1) && m_axis_tready);
    assign in_fire  = s_axis_tvalid && s_axis_tready;

    // After a closing tag in strip mode, a byte that is not a dropped CR/LF behaves as
    // in the start state; unused codes behave as the start state too.
    always_comb begin
        unique case (r_state)
            PS_START_LT, PS_TEXT, PS_TEXT_LT, PS_TAG_OPEN, PS_EXPR, PS_EXPR_Q,
            PS_CODE, PS_CODE_Q, PS_COMM, PS_COMM_Q: start_like = 1'b0;
            PS_NL1:  start_like = (c != CH_CR) && (c != CH_LF);
            PS_NL2:  start_like = (c != CH_LF);
            default: start_like = 1'b1;
        endcase
    end

    // Next state and line count.
    always_comb begin
        n_state = r_state;
        n_line  = r_line;
        if (is_end) begin
            n_state = PS_START;
            n_line  = LINE_BITS'(1);
        end else begin
            if (c == CH_LF && r_line != '1) begin
                n_line = r_line + LINE_BITS'(1);
            end
            if (start_like) begin
                n_state = (c == CH_LT) ? PS_START_LT : PS_TEXT;
            end else begin
                unique case (r_state)
                    PS_START_LT: n_state = (c == CH_QM) ? PS_TAG_OPEN : PS_TEXT;
                    PS_TEXT:     n_state = (c == CH_LT) ? PS_TEXT_LT : PS_TEXT;
                    PS_TEXT_LT:  n_state = (c == CH_QM) ? PS_TAG_OPEN : PS_TEXT;
                    PS_TAG_OPEN: begin
                        priority if (c == CH_EQ)   n_state = PS_EXPR;
                        else if (c == CH_HASH)     n_state = PS_COMM;
                        else                       n_state = PS_CODE;
                    end
                    PS_EXPR:     n_state = (c == CH_QM) ? PS_EXPR_Q : PS_EXPR;
                    PS_CODE:     n_state = (c == CH_QM) ? PS_CODE_Q : PS_CODE;
                    PS_COMM:     n_state = (c == CH_QM) ? PS_COMM_Q : PS_COMM;
                    PS_EXPR_Q, PS_CODE_Q, PS_COMM_Q: begin
                        priority if (c == CH_GT)   n_state = r_strip ? PS_NL1 : PS_START;
                        else if (c == CH_QM)       n_state = r_state;
                        else if (r_state == PS_EXPR_Q) n_state = PS_EXPR;
                        else if (r_state == PS_CODE_Q) n_state = PS_CODE;
                        else                       n_state = PS_COMM;
                    end
                    PS_NL1:      n_state = (c == CH_CR) ? PS_NL2 : PS_START;
                    default:     n_state = PS_START;
                endcase
            end
        end
    end

    // Output selection: a fixed prefix string, the byte itself (raw or escaped), or both; end error flag.
    always_comb begin
        pre_sel  = PRE_NONE;
        tail_sel = TAIL_NONE;
        end_err  = 1'b0;
        if (is_end) begin
            unique case (r_state)
                PS_TEXT: pre_sel = PRE_CLOSE_Q;
                PS_START_LT, PS_TEXT_LT, PS_TAG_OPEN, PS_EXPR, PS_EXPR_Q,
                PS_CODE, PS_CODE_Q, PS_COMM, PS_COMM_Q: end_err = 1'b1;
                default: end_err = 1'b0;
            endcase
        end else if (start_like) begin
            if (c != CH_LT) begin
                pre_sel  = PRE_ECHO_Q;
                tail_sel = TAIL_ESC;
            end
        end else begin
            unique case (r_state)
                PS_START_LT: begin
                    if (c != CH_QM) begin
                        pre_sel  = PRE_ECHO_Q_LT;
                        tail_sel = TAIL_ESC;
                    end
                end
                PS_TEXT: begin
                    if (c != CH_LT) tail_sel = TAIL_ESC;
                end
                PS_TEXT_LT: begin
                    if (c == CH_QM) begin
                        pre_sel = PRE_CLOSE_Q;
                    end else begin
                        pre_sel  = PRE_LT;
                        tail_sel = TAIL_ESC;
                    end
                end
                PS_TAG_OPEN: begin
                    priority if (c == CH_EQ) pre_sel  = PRE_ECHO;
                    else if (c == CH_HASH)   pre_sel  = PRE_NONE;
                    else                     tail_sel = TAIL_RAW;
                end
                PS_EXPR, PS_CODE: begin
                    if (c != CH_QM) tail_sel = TAIL_RAW;
                end
                PS_EXPR_Q, PS_CODE_Q: begin
                    priority if (c == CH_GT) begin
                        pre_sel = (r_state == PS_EXPR_Q) ? PRE_CLOSE : PRE_SPACE;
                    end else if (c == CH_QM) begin
                        pre_sel = PRE_QM;
                    end else begin
                        pre_sel  = PRE_QM;
                        tail_sel = TAIL_RAW;
                    end
                end
                default: begin
                    pre_sel  = PRE_NONE;
                    tail_sel = TAIL_NONE;
                end
            endcase
        end
    end

    assign pre = prefix_of(pre_sel);
    assign esc = escape_of(c);

    always_comb begin
        unique case (tail_sel)
            TAIL_ESC: tail = esc;
            TAIL_RAW: begin
                tail          = '0;
                tail.len      = 2'd1;
                tail.bytes[0] = c;
            end
            default:  tail = '0;
        endcase
    end

    always_comb begin
        logic [CNT_W-1:0] j;
        burst.len = pre.len + CNT_W'(tail.len);
        for (int i = 0; i < MAX_BEATS; i++) begin
            j = CNT_W'(i) - pre.len;
            if (CNT_W'(i) < pre.len) begin
                burst.bytes[i] = pre.bytes[i];
            end else if (j == CNT_W'(0)) begin
                burst.bytes[i] = tail.bytes[0];
            end else if (j == CNT_W'(1)) begin
                burst.bytes[i] = tail.bytes[1];
            end else begin
                burst.bytes[i] = 8'h00;
            end
        end
    end

    // Reported line is the count after this beat's own LF, before an end resets it.
    assign line_wide = LW'(is_end ? r_line : n_line);
    assign line_out  = line_wide[LINE_OUT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strip <= 1'b1;
            r_state <= PS_START;
            r_line  <= LINE_BITS'(1);
            r_cnt   <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_strip <= i_cfg_wr_data;
            end
            if (in_fire) begin
                r_state <= n_state;
                r_line  <= n_line;
            end
            if (in_fire) begin
                if (is_end && burst.len == '0) begin
                    r_cnt <= CNT_W'(1);
                end else begin
                    r_cnt <= burst.len;
                end
            end else if (out_fire) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_buf      <= burst.bytes;
            r_bv       <= !(is_end && burst.len == '0);
            r_err      <= end_err;
            r_end      <= is_end;
            r_line_out <= line_out;
        end else if (out_fire) begin
            for (int i = 0; i < MAX_BEATS - 1; i++) begin
                r_buf[i] <= r_buf[i+1];
            end
            r_buf[MAX_BEATS-1] <= 8'h00;
        end
    end

    assign m_axis_tvalid = (r_cnt != '0);
    assign m_axis_tlast  = (r_cnt == CNT_W'(1));
    assign m_axis_tdata  = {(OUT_TDATA_W - LINE_OUT_W - 8)'(0), r_line_out, r_buf[0]};
    assign m_axis_tuser  = {r_end && m_axis_tlast, r_err, r_bv};

endmodule
